FILE: rtl/core/ofi_pkg.sv
// Shared types and constants for the order-flow-imbalance signal block.
// No dependencies; every other file in rtl/core refers to it by scoped name.
`default_nettype none

package ofi_pkg;

  localparam int PRICE_BITS_DEF = 32;
  localparam int SIZE_BITS_DEF  = 32;

  localparam int FIELD_W     = 32;
  localparam int TERM_W      = 32;
  localparam int ACC_W       = 64;
  localparam int PROD_W      = 96;
  localparam int SCALE_SHIFT = 16;
  localparam int K_W         = 5;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int S_TDATA_W   = 4 * FIELD_W;
  localparam int M_TDATA_W   = 104;

  localparam logic [K_W-1:0]     DECAY_MAX    = 5'd16;
  localparam logic [K_W-1:0]     DECAY_RESET  = 5'd4;
  localparam logic [FIELD_W-1:0] THRESH_RESET = 32'd0;

  // Register index, taken from paddr bit 2
  typedef enum logic {
    REG_DECAY  = 1'b0,
    REG_THRESH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [K_W-1:0]     k;      // decay shift, already saturated to DECAY_MAX
    logic [FIELD_W-1:0] theta;  // threshold, unsigned Q16
  } cfg_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]         depth;
  } upd_t;

endpackage

`default_nettype wire

FILE: rtl/core/ofi_cfg.sv
// Configuration registers behind an APB-style port: decay shift and threshold.
// Depends on ofi_pkg for register indexes, reset values and the cfg_t struct.
`default_nettype none

module ofi_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ofi_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ofi_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ofi_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output ofi_pkg::cfg_t                      cfg
);

  logic [ofi_pkg::K_W-1:0]     decay_shift;
  logic [ofi_pkg::FIELD_W-1:0] threshold_q16;
  ofi_pkg::reg_idx_t           idx;
  logic                        wr;

  assign pready = 1'b1;
  assign idx    = ofi_pkg::reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_shift   <= ofi_pkg::DECAY_RESET;
      threshold_q16 <= ofi_pkg::THRESH_RESET;
    end else if (wr) begin
      unique case (idx)
        ofi_pkg::REG_DECAY:  decay_shift   <= pwdata[ofi_pkg::K_W-1:0];
        ofi_pkg::REG_THRESH: threshold_q16 <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ofi_pkg::REG_DECAY:  prdata = ofi_pkg::PDATA_W'(decay_shift);
      ofi_pkg::REG_THRESH: prdata = threshold_q16;
    endcase
  end

  // Saturate the shift so both averages stay well inside 64 bits
  assign cfg.k     = (decay_shift > ofi_pkg::DECAY_MAX) ? ofi_pkg::DECAY_MAX : decay_shift;
  assign cfg.theta = threshold_q16;

endmodule

`default_nettype wire

FILE: rtl/core/ofi_update.sv
// Input register, stored quote, imbalance term and both EWMA accumulators.
// Depends on ofi_pkg; feeds one upd_t word per quote to ofi_threshold.
`default_nettype none

module ofi_update #(
  parameter int PRICE_BITS = ofi_pkg::PRICE_BITS_DEF,
  parameter int SIZE_BITS  = ofi_pkg::SIZE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ofi_pkg::S_TDATA_W-1:0]   in_data,
  input  wire ofi_pkg::cfg_t                   cfg,
  output logic                                 upd_valid,
  input  wire logic                            upd_ready,
  output ofi_pkg::upd_t                        upd
);

  localparam int PW = (PRICE_BITS > ofi_pkg::FIELD_W) ? ofi_pkg::FIELD_W : PRICE_BITS;
  localparam int SW = SIZE_BITS;
  localparam int EW = SW + 3;
  localparam int DW = SW + 1;
  localparam int FW = ofi_pkg::FIELD_W;
  localparam int AW = ofi_pkg::ACC_W;
  localparam int TW = ofi_pkg::TERM_W;

  logic          q_valid;
  logic [PW-1:0] q_bid_price;
  logic [SW-1:0] q_bid_size;
  logic [PW-1:0] q_ask_price;
  logic [SW-1:0] q_ask_size;

  logic          seeded;
  logic [PW-1:0] last_bid_price;
  logic [SW-1:0] last_bid_size;
  logic [PW-1:0] last_ask_price;
  logic [SW-1:0] last_ask_size;
  logic signed [AW-1:0] acc;
  logic [AW-1:0]        depth;

  logic                 step;
  logic signed [EW-1:0] e;
  logic signed [AW-1:0] e_ext;
  logic signed [TW-1:0] term;
  logic [DW-1:0]        d;
  logic signed [AW-1:0] acc_next;
  logic [AW-1:0]        depth_next;

  assign step     = q_valid && (!upd_valid || upd_ready);
  assign in_ready = !q_valid || step;

  always_comb begin
    e = '0;
    if (q_bid_price >= last_bid_price) e = e + signed'(EW'(q_bid_size));
    if (q_bid_price <= last_bid_price) e = e - signed'(EW'(last_bid_size));
    if (q_ask_price <= last_ask_price) e = e - signed'(EW'(q_ask_size));
    if (q_ask_price >= last_ask_price) e = e + signed'(EW'(last_ask_size));
    e_ext = AW'(e);
    if (e_ext > 64'sh0000_0000_7FFF_FFFF) begin
      term = 32'sh7FFF_FFFF;
    end else if (e_ext < 64'shFFFF_FFFF_8000_0000) begin
      term = 32'sh8000_0000;
    end else begin
      term = e_ext[TW-1:0];
    end
    acc_next = acc - (acc >>> cfg.k) + AW'(term);
    d        = DW'(q_bid_size) + DW'(q_ask_size);
    if (!seeded) begin
      depth_next = AW'(d) << cfg.k;
    end else begin
      depth_next = depth - (depth >> cfg.k) + AW'(d);
    end
  end

  // Control and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      upd_valid <= 1'b0;
      seeded    <= 1'b0;
      acc       <= '0;
      depth     <= '0;
    end else begin
      if (in_ready) q_valid <= in_valid;
      if (!upd_valid || upd_ready) upd_valid <= q_valid;
      if (step) begin
        seeded <= 1'b1;
        depth  <= depth_next;
        if (seeded) acc <= acc_next;
      end
    end
  end

  // Payload: input register, stored quote, result word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_bid_price <= in_data[0 +: PW];
      q_bid_size  <= in_data[FW +: SW];
      q_ask_price <= in_data[2*FW +: PW];
      q_ask_size  <= in_data[3*FW +: SW];
    end
    if (step) begin
      last_bid_price <= q_bid_price;
      last_bid_size  <= q_bid_size;
      last_ask_price <= q_ask_price;
      last_ask_size  <= q_ask_size;
      upd.depth      <= depth_next;
      if (seeded) begin
        upd.term <= term;
        upd.acc  <= acc_next;
      end else begin
        upd.term <= '0;
        upd.acc  <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_seeded_sticks: assert property (@(posedge clk) disable iff (rst)
    seeded |=> seeded)
    else $error("seeded flag dropped without reset");

  a_seed_word_zero: assert property (@(posedge clk) disable iff (rst)
    (step && !seeded) |=> (upd_valid && upd.acc == '0 && upd.term == '0))
    else $error("seed quote produced a non-zero word");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ofi_threshold.sv
// Threshold pipeline: split threshold*depth product, sum, shift and compare.
// Depends on ofi_pkg; drives the output register of the result stream.
`default_nettype none

module ofi_threshold (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ofi_pkg::cfg_t                 cfg,
  input  wire logic                          upd_valid,
  output logic                               upd_ready,
  input  wire ofi_pkg::upd_t                 upd,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [ofi_pkg::TERM_W-1:0]  out_term,
  output logic signed [ofi_pkg::ACC_W-1:0]   out_acc,
  output logic                               out_buy,
  output logic                               out_sell
);

  localparam int AW = ofi_pkg::ACC_W;
  localparam int TW = ofi_pkg::TERM_W;
  localparam int PW = ofi_pkg::PROD_W;
  localparam int FW = ofi_pkg::FIELD_W;
  localparam int SS = ofi_pkg::SCALE_SHIFT;

  logic                 a_valid, b_valid;
  logic                 a_ready, b_ready, c_ready;
  logic [AW-1:0]        a_p0, a_p1, a_mag, b_mag;
  logic signed [TW-1:0] a_term, b_term;
  logic signed [AW-1:0] a_acc, b_acc;
  logic [PW-1:0]        b_prod;
  logic [AW-1:0]        mag;
  logic [PW-1:0]        bound;
  logic [PW-1:0]        scaled;
  logic                 over;

  assign c_ready   = !out_valid || out_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign upd_ready = a_ready;

  assign mag    = upd.acc[AW-1] ? (~upd.acc + AW'(1)) : upd.acc;
  assign bound  = b_prod >> cfg.k;
  assign scaled = {{(PW-AW-SS){1'b0}}, b_mag, {SS{1'b0}}};
  assign over   = scaled > bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= upd_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    // Two 32x32 partial products of threshold * depth
    if (upd_valid && a_ready) begin
      a_p0   <= AW'(cfg.theta) * AW'(upd.depth[FW-1:0]);
      a_p1   <= AW'(cfg.theta) * AW'(upd.depth[AW-1:FW]);
      a_term <= upd.term;
      a_acc  <= upd.acc;
      a_mag  <= mag;
    end
    if (a_valid && b_ready) begin
      b_prod <= PW'(a_p0) + {a_p1, {FW{1'b0}}};
      b_term <= a_term;
      b_acc  <= a_acc;
      b_mag  <= a_mag;
    end
    if (b_valid && c_ready) begin
      out_term <= b_term;
      out_acc  <= b_acc;
      out_buy  <= over && (b_acc != '0) && !b_acc[AW-1];
      out_sell <= over && b_acc[AW-1];
    end
  end

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_buy && out_sell))
    else $error("buy and sell flagged together");

  a_zero_no_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_acc == '0) |-> (!out_buy && !out_sell))
    else $error("flag raised on a zero average");

  a_flag_sign: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_buy || out_sell)) |-> (out_buy == !out_acc[AW-1]))
    else $error("flag disagrees with sign of average");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/order_flow_imbalance_signal.sv
// Top level of the order-flow-imbalance signal: config port, update stage, threshold pipe.
// Depends on ofi_pkg, ofi_cfg, ofi_update and ofi_threshold.
//
//   port group   dir   word                              handshake
//   s_*          in    one top-of-book quote              tvalid & tready
//   m_*          out   term, average, buy/sell flags      tvalid & tready
//   p*           in    register write / read (APB-style)  psel & penable & pready
//
// One quote per cycle sustained unless m_tready stalls; stages from quote to m_tvalid, in order:
// input register, accumulator update (the feedback loop on the averages), two 32x32 partial
// products of threshold*depth, product sum, then shift and compare into the output register.
// Reset clears seeded, both averages and the pipe; decay_shift returns to 4, threshold to 0.
// A stall on m_tready fills empty stages first, then drops s_tready.
`default_nettype none

module order_flow_imbalance_signal #(
  parameter int PRICE_BITS = ofi_pkg::PRICE_BITS_DEF,
  parameter int SIZE_BITS  = ofi_pkg::SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // bid_price[31:0], bid_size[63:32], ask_price[95:64], ask_size[127:96]
  input  wire logic [ofi_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // event_term[31:0], imbalance_average[95:32], buy_pressure[96], sell_pressure[97], zero pad
  output logic [ofi_pkg::M_TDATA_W-1:0]      m_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ofi_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ofi_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ofi_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  ofi_pkg::cfg_t cfg;
  ofi_pkg::upd_t upd;
  logic          upd_valid;
  logic          upd_ready;

  logic signed [ofi_pkg::TERM_W-1:0] out_term;
  logic signed [ofi_pkg::ACC_W-1:0]  out_acc;
  logic                              out_buy;
  logic                              out_sell;

  ofi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ofi_update #(
    .PRICE_BITS (PRICE_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .cfg       (cfg),
    .upd_valid (upd_valid),
    .upd_ready (upd_ready),
    .upd       (upd)
  );

  ofi_threshold u_threshold (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .upd_valid (upd_valid),
    .upd_ready (upd_ready),
    .upd       (upd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_term  (out_term),
    .out_acc   (out_acc),
    .out_buy   (out_buy),
    .out_sell  (out_sell)
  );

  assign m_tdata = {6'b0, out_sell, out_buy, out_acc, out_term};

endmodule

`default_nettype wire
